FILE: rtl/hse_pkg.sv
// ----------------------------------------------------------------------------
// hse_pkg
// Shared sizes, microcode control word layout and microprogram for the heap
// sort engine.
// ----------------------------------------------------------------------------
package hse_pkg;

  // Store size and derived widths
  localparam int unsigned MAX_ITEMS = 64;
  localparam int unsigned ADDR_W    = $clog2(MAX_ITEMS);
  localparam int unsigned CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int unsigned IDX_W     = ADDR_W + 2;  // holds 2*node+2
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned UPC_W     = 5;

  typedef logic [UPC_W-1:0] upc_t;

  // Datapath actions, one per control word
  typedef enum logic [3:0] {
    A_NONE,
    A_LOAD,    // take an input word into the store
    A_BINIT,   // heap length = count, k = count / 2, build phase
    A_BSTART,  // k--, node = k-1, read node
    A_CAPN,    // latch the sifting value
    A_SREADL,  // top = node, read left child
    A_CMPL,    // compare left child, read right child
    A_CMPR,    // compare right child
    A_SMOVE,   // write larger value at node, node = top
    A_RD0,     // read root, sort phase
    A_RDEND,   // hold root, read heap end
    A_SWAP,    // root to heap end, shrink heap, sift from root
    A_EINIT,   // k = 0
    A_EREAD,   // read slot k, k++
    A_EPUSH,   // load output register
    A_CLR      // clear count and drop flag
  } act_e;

  // Jump conditions
  typedef enum logic [3:0] {
    C_NEXT,
    C_ALWAYS,
    C_NO_LAST,
    C_K_ZERO,
    C_LEFT_OUT,
    C_RIGHT_OUT,
    C_TOP_MOVED,
    C_BUILD,
    C_LEN_LE1,
    C_OUT_BUSY,
    C_K_LT_CNT
  } cond_e;

  typedef struct packed {
    act_e  act;
    cond_e cond;
    upc_t  target;
  } ucode_t;

  // Sequencer to datapath
  typedef struct packed {
    act_e act;
    logic in_fire;
  } hse_ctrl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic k_zero;
    logic left_out;
    logic right_out;
    logic top_moved;
    logic build;
    logic len_le1;
    logic k_lt_cnt;
    logic k_eq_cnt;
    logic dropped;
  } hse_stat_t;

  // Step addresses
  localparam upc_t U_LOAD   = 5'd0;
  localparam upc_t U_BINIT  = 5'd1;
  localparam upc_t U_BTEST  = 5'd2;
  localparam upc_t U_BSTART = 5'd3;
  localparam upc_t U_CAPN   = 5'd4;
  localparam upc_t U_SREADL = 5'd5;
  localparam upc_t U_CMPL   = 5'd6;
  localparam upc_t U_CMPR   = 5'd7;
  localparam upc_t U_SMOVE  = 5'd8;
  localparam upc_t U_SEND   = 5'd9;
  localparam upc_t U_STEST  = 5'd10;
  localparam upc_t U_RDEND  = 5'd11;
  localparam upc_t U_SWAP   = 5'd12;
  localparam upc_t U_EINIT  = 5'd13;
  localparam upc_t U_EREAD  = 5'd14;
  localparam upc_t U_EPUSH  = 5'd15;
  localparam upc_t U_ETEST  = 5'd16;
  localparam upc_t U_CLR    = 5'd17;

  // Microprogram ROM
  function automatic ucode_t ucode_rom(upc_t pc);
    ucode_t w;
    case (pc)
      U_LOAD:   w = '{A_LOAD,   C_NO_LAST,   U_LOAD};
      U_BINIT:  w = '{A_BINIT,  C_NEXT,      U_LOAD};
      U_BTEST:  w = '{A_NONE,   C_K_ZERO,    U_STEST};
      U_BSTART: w = '{A_BSTART, C_NEXT,      U_LOAD};
      U_CAPN:   w = '{A_CAPN,   C_NEXT,      U_LOAD};
      U_SREADL: w = '{A_SREADL, C_LEFT_OUT,  U_SMOVE};
      U_CMPL:   w = '{A_CMPL,   C_RIGHT_OUT, U_SMOVE};
      U_CMPR:   w = '{A_CMPR,   C_NEXT,      U_LOAD};
      U_SMOVE:  w = '{A_SMOVE,  C_TOP_MOVED, U_SREADL};
      U_SEND:   w = '{A_NONE,   C_BUILD,     U_BTEST};
      U_STEST:  w = '{A_RD0,    C_LEN_LE1,   U_EINIT};
      U_RDEND:  w = '{A_RDEND,  C_NEXT,      U_LOAD};
      U_SWAP:   w = '{A_SWAP,   C_ALWAYS,    U_SREADL};
      U_EINIT:  w = '{A_EINIT,  C_NEXT,      U_LOAD};
      U_EREAD:  w = '{A_EREAD,  C_NEXT,      U_LOAD};
      U_EPUSH:  w = '{A_EPUSH,  C_OUT_BUSY,  U_EPUSH};
      U_ETEST:  w = '{A_NONE,   C_K_LT_CNT,  U_EREAD};
      U_CLR:    w = '{A_CLR,    C_ALWAYS,    U_LOAD};
      default:  w = '{A_NONE,   C_ALWAYS,    U_LOAD};
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/hse_datapath.sv
// ----------------------------------------------------------------------------
// hse_datapath
// Element store, index registers and signed compare driven by the
// microcode action of the current step.
// ----------------------------------------------------------------------------
module hse_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  hse_pkg::hse_ctrl_t          ctrl_i,
  input  logic [hse_pkg::DATA_W-1:0]  in_value_i,
  output hse_pkg::hse_stat_t          stat_o,
  output logic [hse_pkg::DATA_W-1:0]  rdata_o
);
  import hse_pkg::*;

  logic [DATA_W-1:0] mem [MAX_ITEMS];

  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              drop_q, drop_d;
  logic [CNT_W-1:0]  k_q, k_d;
  logic [CNT_W-1:0]  len_q, len_d;
  logic [ADDR_W-1:0] node_q, node_d;
  logic [ADDR_W-1:0] top_q, top_d;
  logic              build_q, build_d;
  logic signed [DATA_W-1:0] nval_q, nval_d;
  logic signed [DATA_W-1:0] tval_q, tval_d;
  logic signed [DATA_W-1:0] rdata_q;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;

  logic [IDX_W-1:0]  left_w, right_w, len_x;
  logic [CNT_W-1:0]  k_dec, len_dec;
  logic              left_gt, right_gt;

  assign left_w   = IDX_W'({node_q, 1'b1});
  assign right_w  = left_w + IDX_W'(1);
  assign len_x    = IDX_W'(len_q);
  assign k_dec    = k_q - CNT_W'(1);
  assign len_dec  = len_q - CNT_W'(1);
  assign left_gt  = rdata_q > tval_q;
  assign right_gt = rdata_q > tval_q;

  // Status back to the sequencer
  assign stat_o.k_zero    = (k_q == '0);
  assign stat_o.left_out  = (left_w >= len_x);
  assign stat_o.right_out = (right_w >= len_x);
  assign stat_o.top_moved = (top_q != node_q);
  assign stat_o.build     = build_q;
  assign stat_o.len_le1   = (len_q <= CNT_W'(1));
  assign stat_o.k_lt_cnt  = (k_q < cnt_q);
  assign stat_o.k_eq_cnt  = (k_q == cnt_q);
  assign stat_o.dropped   = drop_q;
  assign rdata_o          = rdata_q;

  // Decode the action into register updates and store accesses
  always_comb begin
    cnt_d   = cnt_q;
    drop_d  = drop_q;
    k_d     = k_q;
    len_d   = len_q;
    node_d  = node_q;
    top_d   = top_q;
    build_d = build_q;
    nval_d  = nval_q;
    tval_d  = tval_q;
    wr_en   = 1'b0;
    wr_addr = node_q;
    wr_data = tval_q;
    rd_en   = 1'b0;
    rd_addr = node_q;
    case (ctrl_i.act)
      A_LOAD: begin
        if (ctrl_i.in_fire) begin
          if (cnt_q < CNT_W'(MAX_ITEMS)) begin
            wr_en   = 1'b1;
            wr_addr = cnt_q[ADDR_W-1:0];
            wr_data = in_value_i;
            cnt_d   = cnt_q + CNT_W'(1);
          end else begin
            drop_d = 1'b1;
          end
        end
      end
      A_BINIT: begin
        len_d   = cnt_q;
        k_d     = cnt_q >> 1;
        build_d = 1'b1;
      end
      A_BSTART: begin
        k_d     = k_dec;
        node_d  = k_dec[ADDR_W-1:0];
        rd_en   = 1'b1;
        rd_addr = k_dec[ADDR_W-1:0];
      end
      A_CAPN: begin
        nval_d = rdata_q;
      end
      A_SREADL: begin
        top_d   = node_q;
        tval_d  = nval_q;
        rd_en   = 1'b1;
        rd_addr = left_w[ADDR_W-1:0];
      end
      A_CMPL: begin
        if (left_gt) begin
          top_d  = left_w[ADDR_W-1:0];
          tval_d = rdata_q;
        end
        rd_en   = 1'b1;
        rd_addr = right_w[ADDR_W-1:0];
      end
      A_CMPR: begin
        if (right_gt) begin
          top_d  = right_w[ADDR_W-1:0];
          tval_d = rdata_q;
        end
      end
      A_SMOVE: begin
        // larger child moves up; with no larger child this is the sifting value
        wr_en   = 1'b1;
        wr_addr = node_q;
        wr_data = tval_q;
        node_d  = top_q;
      end
      A_RD0: begin
        build_d = 1'b0;
        rd_en   = 1'b1;
        rd_addr = '0;
      end
      A_RDEND: begin
        tval_d  = rdata_q;
        rd_en   = 1'b1;
        rd_addr = len_dec[ADDR_W-1:0];
      end
      A_SWAP: begin
        wr_en   = 1'b1;
        wr_addr = len_dec[ADDR_W-1:0];
        wr_data = tval_q;
        nval_d  = rdata_q;
        len_d   = len_dec;
        node_d  = '0;
      end
      A_EINIT: begin
        k_d = '0;
      end
      A_EREAD: begin
        rd_en   = 1'b1;
        rd_addr = k_q[ADDR_W-1:0];
        k_d     = k_q + CNT_W'(1);
      end
      A_CLR: begin
        cnt_d  = '0;
        drop_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Control and index registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      drop_q  <= 1'b0;
      k_q     <= '0;
      len_q   <= '0;
      node_q  <= '0;
      top_q   <= '0;
      build_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      drop_q  <= drop_d;
      k_q     <= k_d;
      len_q   <= len_d;
      node_q  <= node_d;
      top_q   <= top_d;
      build_q <= build_d;
    end
  end

  // Value registers
  always_ff @(posedge clk_i) begin
    nval_q <= nval_d;
    tval_q <= tval_d;
  end

  // Element store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/heap_sort_engine_unit.sv
// ----------------------------------------------------------------------------
// heap_sort_engine_unit
// Heapsort engine: collects a set of signed words, sorts it in place and
// streams it back in ascending order.
// ----------------------------------------------------------------------------
// Load words on the slave stream, one per cycle, until a word with tlast set;
// up to 64 words are kept and any beyond that are dropped, which sets tuser
// on every result of that set. The block then builds a max-heap and sorts in
// place, taking no input, and streams the set out smallest first with tlast
// on the largest word. Sorting runs on a microcoded sequencer over one
// single-port-read store, so each sift level reads the left child, compares
// the children that exist and moves the larger value up, and each heap node
// or sort step adds setup steps of its own. Emitting reads each word, loads
// it into the output register and tests for the set end, waiting while the
// output is held. A new set is accepted after the end test and clear steps
// that follow the last result entering the output register.
module heap_sort_engine_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value
  input  logic        s_axis_tlast,   // last_in
  // master stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] sorted_value
  output logic        m_axis_tlast,   // last_out
  output logic        m_axis_tuser    // overflow
);
  import hse_pkg::*;

  upc_t        pc_q, pc_d;
  ucode_t      uc;
  hse_ctrl_t   ctrl;
  hse_stat_t   stat;
  logic [DATA_W-1:0] dp_rdata;
  logic        in_fire;
  logic        out_free;
  logic        out_load;
  logic        jump;

  logic              m_valid_q;
  logic [DATA_W-1:0] m_data_q;
  logic              m_last_q;
  logic              m_user_q;

  assign uc            = ucode_rom(pc_q);
  assign s_axis_tready = (uc.act == A_LOAD);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign out_load      = (uc.act == A_EPUSH) && out_free;

  assign ctrl.act     = uc.act;
  assign ctrl.in_fire = in_fire;

  hse_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .in_value_i (s_axis_tdata),
    .stat_o     (stat),
    .rdata_o    (dp_rdata)
  );

  // Evaluate the jump condition and pick the next step
  always_comb begin
    case (uc.cond)
      C_NEXT:      jump = 1'b0;
      C_ALWAYS:    jump = 1'b1;
      C_NO_LAST:   jump = !(in_fire && s_axis_tlast);
      C_K_ZERO:    jump = stat.k_zero;
      C_LEFT_OUT:  jump = stat.left_out;
      C_RIGHT_OUT: jump = stat.right_out;
      C_TOP_MOVED: jump = stat.top_moved;
      C_BUILD:     jump = stat.build;
      C_LEN_LE1:   jump = stat.len_le1;
      C_OUT_BUSY:  jump = !out_free;
      C_K_LT_CNT:  jump = stat.k_lt_cnt;
      default:     jump = 1'b0;
    endcase
    pc_d = jump ? uc.target : pc_q + UPC_W'(1);
  end

  // Step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= U_LOAD;
    end else begin
      pc_q <= pc_d;
    end
  end

  // Output register: hold until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= dp_rdata;
      m_last_q <= stat.k_eq_cnt;
      m_user_q <= stat.dropped;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;
  assign m_axis_tuser  = m_user_q;

`ifndef SYNTH
  // never overwrite a word that is still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!m_valid_q || m_axis_tready))
    else $error("output word overwritten");

  // the step counter stays inside the program
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q <= U_CLR)
    else $error("step counter out of program");

  // a set end stops input until the set is sorted and emitted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && s_axis_tlast) |=> !s_axis_tready)
    else $error("input taken after set end");
`endif

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for heap_sort_engine_unit: streams sets of signed
// words, predicts the ascending output of each set with a heapsort of its
// own, and checks every output word against that prediction.
// ----------------------------------------------------------------------------
module tb;
  import hse_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_LEN    = 400;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              last;
  } set_word_t;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              last;
    logic              overflow;
  } sorted_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // [31:0] value
  logic        s_axis_tlast = 1'b0; // last_in
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // [31:0] sorted_value
  logic        m_axis_tlast;        // last_out
  logic        m_axis_tuser;        // overflow

  // words waiting to be offered, and sorted words waiting to come back
  set_word_t    pending_q[$];
  sorted_word_t sorted_q[$];

  // model of the block's store
  logic [DATA_W-1:0] set_buf [MAX_ITEMS];
  int unsigned       set_count = 0;
  logic              set_dropped = 1'b0;

  int unsigned  err_cnt = 0;
  int unsigned  cycle_cnt = 0;
  int           gap_cnt;
  int           burst_cnt;
  int unsigned  rx_cycle;
  int unsigned  hold_cnt;
  int unsigned  hold_num;
  int unsigned  rx_mode;
  int unsigned  rx_mode_cnt;
  sorted_word_t got_w;
  sorted_word_t exp_w;

  heap_sort_engine_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // sift one node down a max-heap of len entries
  task automatic sift_node(input int unsigned start, input int unsigned len);
    int unsigned       node;
    int unsigned       left;
    int unsigned       right;
    int unsigned       top;
    logic [DATA_W-1:0] tmp;
    bit                done;
    node = start;
    done = 1'b0;
    while (!done) begin
      left  = 2 * node + 1;
      right = left + 1;
      top   = node;
      if (left < len && $signed(set_buf[top]) < $signed(set_buf[left])) top = left;
      if (right < len && $signed(set_buf[top]) < $signed(set_buf[right])) top = right;
      if (top == node) begin
        done = 1'b1;
      end else begin
        tmp           = set_buf[node];
        set_buf[node] = set_buf[top];
        set_buf[top]  = tmp;
        node          = top;
      end
    end
  endtask

  // take one accepted word; on the set end, sort and queue the sorted words
  task automatic collect_word(input logic [DATA_W-1:0] value, input logic last);
    int unsigned       k;
    logic [DATA_W-1:0] tmp;
    sorted_word_t      w;
    if (set_count < MAX_ITEMS) begin
      set_buf[set_count] = value;
      set_count++;
    end else begin
      set_dropped = 1'b1;
    end
    if (last) begin
      // build the heap, then move the root to the end of a shrinking heap
      for (k = set_count / 2; k > 0; k--) sift_node(k - 1, set_count);
      for (k = set_count; k > 1; k--) begin
        tmp            = set_buf[0];
        set_buf[0]     = set_buf[k - 1];
        set_buf[k - 1] = tmp;
        sift_node(0, k - 1);
      end
      for (k = 0; k < set_count; k++) begin
        w.value    = set_buf[k];
        w.last     = (k + 1 == set_count);
        w.overflow = set_dropped;
        sorted_q   = {sorted_q, w};
      end
      set_count   = 0;
      set_dropped = 1'b0;
    end
  endtask

  task automatic push_word(input logic [DATA_W-1:0] value, input logic last);
    set_word_t w;
    w.value   = value;
    w.last    = last;
    pending_q = {pending_q, w};
  endtask

  // queue a set of n words with mixed value kinds
  task automatic push_set(input int unsigned n);
    int unsigned       i;
    logic [DATA_W-1:0] v;
    for (i = 0; i < n; i++) begin
      case ($urandom_range(0, 7))
        0: begin
          case ($urandom_range(0, 3))
            0: v = 32'h8000_0000;
            1: v = 32'h7FFF_FFFF;
            2: v = 32'hFFFF_FFFF;
            default: v = 32'h0000_0000;
          endcase
        end
        1, 2: v = $urandom_range(0, 15) - 8;  // narrow range for duplicates
        default: v = $urandom;
      endcase
      push_word(v, i + 1 == n);
    end
  endtask

  // sender: bursts of random length with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tlast  <= 1'b0;
      gap_cnt       <= 0;
      burst_cnt     <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        collect_word(pending_q[0].value, pending_q[0].last);
        void'(pending_q.pop_front());
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_cnt != 0) begin
          gap_cnt       <= gap_cnt - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_q.size() != 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pending_q[0].value;
          s_axis_tlast  <= pending_q[0].last;
          if (burst_cnt == 0) begin
            burst_cnt <= $urandom_range(1, 40);
            gap_cnt   <= ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(0, 3);
          end else begin
            burst_cnt <= burst_cnt - 1;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: changing stall patterns, plus long hold-offs while the block
  // has a word waiting, so that it backs up and stalls its input
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_cycle      <= 0;
      hold_cnt      <= 0;
      hold_num      <= 0;
      rx_mode       <= 0;
      rx_mode_cnt   <= 0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (hold_cnt != 0) begin
        hold_cnt      <= hold_cnt - 1;
        m_axis_tready <= 1'b0;
      end else if (m_axis_tvalid && ((hold_num == 0 && rx_cycle >= 1500) ||
                                     (hold_num == 1 && rx_cycle >= 9000))) begin
        hold_cnt      <= HOLD_LEN;
        hold_num      <= hold_num + 1;
        m_axis_tready <= 1'b0;
      end else begin
        if (rx_mode_cnt == 0) begin
          rx_mode     <= $urandom_range(0, 3);
          rx_mode_cnt <= $urandom_range(20, 120);
        end else begin
          rx_mode_cnt <= rx_mode_cnt - 1;
        end
        case (rx_mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= $urandom_range(0, 1);
          2: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= rx_cycle[2];
        endcase
      end
    end
  end

  // compare each output word with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_w = '{m_axis_tdata, m_axis_tlast, m_axis_tuser};
      if (sorted_q.size() == 0) begin
        $display("%0t: unexpected word value %h last %b overflow %b",
                 $time, got_w.value, got_w.last, got_w.overflow);
        err_cnt++;
      end else begin
        exp_w = sorted_q.pop_front();
        if (got_w.value !== exp_w.value) begin
          $display("%0t: sorted_value expected %h actual %h",
                   $time, exp_w.value, got_w.value);
          err_cnt++;
        end
        if (got_w.last !== exp_w.last) begin
          $display("%0t: last_out expected %b actual %b", $time, exp_w.last, got_w.last);
          err_cnt++;
        end
        if (got_w.overflow !== exp_w.overflow) begin
          $display("%0t: overflow expected %b actual %b",
                   $time, exp_w.overflow, got_w.overflow);
          err_cnt++;
        end
      end
    end
  end

  // hard stop
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int unsigned total;
    int unsigned set_idx;
    int unsigned n;

    // single words at both extremes
    push_word(32'h7FFF_FFFF, 1'b1);
    push_word(32'h8000_0000, 1'b1);
    // mixed extremes and bit patterns
    push_word(32'h0000_0000, 1'b0);
    push_word(32'hFFFF_FFFF, 1'b0);
    push_word(32'h8000_0000, 1'b0);
    push_word(32'h7FFF_FFFF, 1'b0);
    push_word(32'h0000_0001, 1'b0);
    push_word(32'h5555_5555, 1'b0);
    push_word(32'hAAAA_AAAA, 1'b1);
    // equal values
    push_word(32'd5, 1'b0);
    push_word(32'd5, 1'b0);
    push_word(32'd5, 1'b0);
    push_word(-32'sd5, 1'b0);
    push_word(-32'sd5, 1'b1);
    // two words, already ascending and descending
    push_word(-32'sd10, 1'b0);
    push_word(32'd10, 1'b1);
    push_word(32'd10, 1'b0);
    push_word(-32'sd10, 1'b1);

    // random sets: mostly small, a full store, and sets that overrun it
    total   = 0;
    set_idx = 0;
    while (total < 430) begin
      case (set_idx)
        3:  n = MAX_ITEMS;
        6:  n = MAX_ITEMS + 1;   // the last word itself is dropped
        10: n = MAX_ITEMS + 6;
        14: n = MAX_ITEMS - 1;
        default: n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                 : $urandom_range(1, 12);
      endcase
      push_set(n);
      total += n;
      set_idx++;
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // drain input, then output, then let the block settle
    while (pending_q.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (sorted_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    if (err_cnt == 0 && sorted_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
